// ----- rtl/core/pws_pkg.sv -----
`timescale 1ns / 1ps

package pws_pkg;

    // fixed-point word width of every coordinate and coefficient
    localparam int FIX_W = 32;
    localparam int NUM_CFG = 7;
    localparam int COEF_REGS = 6;
    localparam int DIMS_IDX = 6;
    localparam logic [31:0] DIMS_RESET = 32'd70780800;

    typedef logic signed [FIX_W-1:0] t_fix;
    typedef t_fix [3:0] t_row;
    typedef t_row [2:0] t_mat;

    // clip-space values handed from the matrix unit to the divider
    typedef struct packed {
        t_fix cx;
        t_fix cy;
        t_fix cw;
    } t_clip;

    // normalized values handed from the divider to the pixel mapping
    typedef struct packed {
        logic vis;
        t_fix nx;
        t_fix ny;
    } t_ndc;

    // saturate a wide signed value to the fixed-point range
    function automatic t_fix sat_fix(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        hi = 72'sd2147483647;
        lo = -72'sd2147483648;
        if (v > hi) begin
            return t_fix'(hi);
        end else if (v < lo) begin
            return t_fix'(lo);
        end else begin
            return t_fix'(v);
        end
    endfunction

endpackage

// ----- rtl/core/pws_clip.sv -----
`timescale 1ns / 1ps

module pws_clip
    import pws_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_fix  i_pos_x,
    input  t_fix  i_pos_y,
    input  t_fix  i_pos_z,
    input  t_mat  i_mat,
    output logic  o_valid,
    output t_clip o_clip
);

    logic signed [63:0] r_prod [3][3];
    logic               r_vld_a;
    logic               r_vld_b;
    t_clip              r_clip;
    t_fix               n_res [3];

    // stage a: nine products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r_prod[r][0] <= $signed(i_mat[r][0]) * $signed(i_pos_x);
                r_prod[r][1] <= $signed(i_mat[r][1]) * $signed(i_pos_y);
                r_prod[r][2] <= $signed(i_mat[r][2]) * $signed(i_pos_z);
            end
        end
    end

    // stage b: floor shift, sum with offset column, saturate
    always_comb begin
        logic signed [71:0] acc;
        for (int r = 0; r < 3; r++) begin
            acc = 72'(r_prod[r][0] >>> FRAC_BITS) + 72'(r_prod[r][1] >>> FRAC_BITS)
                + 72'(r_prod[r][2] >>> FRAC_BITS) + 72'($signed(i_mat[r][3]));
            n_res[r] = sat_fix(acc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_clip.cx <= n_res[0];
            r_clip.cy <= n_res[1];
            r_clip.cw <= n_res[2];
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    assign o_valid = r_vld_b;
    assign o_clip  = r_clip;

endmodule

// ----- rtl/core/pws_div.sv -----
`timescale 1ns / 1ps

module pws_div
    import pws_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_clip i_clip,
    output logic  o_valid,
    output t_ndc  o_ndc
);

    localparam int DW = FIX_W + FRAC_BITS;
    localparam logic signed [FIX_W-1:0] WMIN =
        FIX_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

    // per-bit stage registers, index 0 is the operand setup stage
    logic [FIX_W-1:0] r_rem [2][DW+1];
    logic [DW-1:0]    r_num [2][DW+1];
    logic [DW-1:0]    r_q   [2][DW+1];
    logic             r_neg [2][DW+1];
    logic [FIX_W-1:0] r_w   [DW+1];
    logic             r_vis [DW+1];
    logic             r_vld [DW+1];

    logic [FIX_W-1:0] n_rem [2][DW+1];
    logic [DW-1:0]    n_num [2][DW+1];
    logic [DW-1:0]    n_q   [2][DW+1];

    t_ndc             r_ndc;
    logic             r_out_vld;
    t_fix             n_quot [2];

    // setup operands (magnitude of the dividend, scaled by one),
    // then one restoring quotient bit per stage
    always_comb begin
        t_fix             num;
        logic [FIX_W-1:0] mag;
        logic [FIX_W:0]   t;
        logic             ge;
        for (int l = 0; l < 2; l++) begin
            num = (l == 0) ? i_clip.cx : i_clip.cy;
            mag = num[FIX_W-1] ? FIX_W'(-num) : FIX_W'(num);
            n_rem[l][0] = '0;
            n_num[l][0] = {mag, {FRAC_BITS{1'b0}}};
            n_q[l][0]   = '0;
            for (int k = 1; k <= DW; k++) begin
                t  = {r_rem[l][k-1], r_num[l][k-1][DW-1]};
                ge = (t >= {1'b0, r_w[k-1]});
                n_rem[l][k] = ge ? FIX_W'(t - {1'b0, r_w[k-1]}) : t[FIX_W-1:0];
                n_num[l][k] = r_num[l][k-1] << 1;
                n_q[l][k]   = {r_q[l][k-1][DW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                for (int k = 0; k <= DW; k++) begin
                    r_rem[l][k] <= n_rem[l][k];
                    r_num[l][k] <= n_num[l][k];
                    r_q[l][k]   <= n_q[l][k];
                end
            end
            r_neg[0][0] <= i_clip.cx[FIX_W-1];
            r_neg[1][0] <= i_clip.cy[FIX_W-1];
            r_w[0]      <= i_clip.cw;
            r_vis[0]    <= (i_clip.cw >= WMIN);
            for (int k = 1; k <= DW; k++) begin
                r_neg[0][k] <= r_neg[0][k-1];
                r_neg[1][k] <= r_neg[1][k-1];
                r_w[k]      <= r_w[k-1];
                r_vis[k]    <= r_vis[k-1];
            end
        end
    end

    // apply sign and saturate the quotient
    always_comb begin
        logic [DW-1:0] q;
        logic          big;
        for (int l = 0; l < 2; l++) begin
            q   = r_q[l][DW];
            big = (q[DW-1:FIX_W-1] != '0);
            if (r_neg[l][DW]) begin
                n_quot[l] = big ? t_fix'({1'b1, {(FIX_W-1){1'b0}}})
                                : t_fix'(-q[FIX_W-1:0]);
            end else begin
                n_quot[l] = big ? t_fix'({1'b0, {(FIX_W-1){1'b1}}})
                                : t_fix'(q[FIX_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ndc.vis <= r_vis[DW];
            r_ndc.nx  <= n_quot[0];
            r_ndc.ny  <= n_quot[1];
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k <= DW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_vld <= r_vld[DW];
        end
    end

    assign o_valid = r_out_vld;
    assign o_ndc   = r_ndc;

endmodule

// ----- rtl/core/pws_map.sv -----
`timescale 1ns / 1ps

module pws_map
    import pws_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_ndc        i_ndc,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    output logic        o_valid,
    output logic        o_visible,
    output t_fix        o_screen_x,
    output t_fix        o_screen_y
);

    localparam logic signed [55:0] HALF = 56'(1) << (FRAC_BITS - 1);

    logic signed [48:0] r_px;
    logic signed [48:0] r_py;
    logic               r_vis;
    logic               r_vld_a;
    logic               r_vld_b;
    logic               r_visible;
    t_fix               r_sx;
    t_fix               r_sy;
    t_fix               n_sx;
    t_fix               n_sy;

    // stage a: scale by screen size
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= $signed(i_ndc.nx) * $signed({1'b0, i_width});
            r_py  <= $signed(i_ndc.ny) * $signed({1'b0, i_height});
            r_vis <= i_ndc.vis;
        end
    end

    // stage b: halve, center, round, saturate
    always_comb begin
        logic signed [55:0] bx;
        logic signed [55:0] by;
        logic signed [55:0] tx;
        logic signed [55:0] ty;
        bx = $signed({40'd0, i_width}) <<< (FRAC_BITS - 1);
        by = $signed({40'd0, i_height}) <<< (FRAC_BITS - 1);
        tx = 56'(r_px >>> 1) + HALF;
        ty = 56'(r_py >>> 1) + HALF;
        n_sx = r_vis ? sat_fix(72'(bx + tx)) : '0;
        n_sy = r_vis ? sat_fix(72'(by - ty)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx      <= n_sx;
            r_sy      <= n_sy;
            r_visible <= r_vis;
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
        end
    end

    assign o_valid    = r_vld_b;
    assign o_visible  = r_visible;
    assign o_screen_x = r_sx;
    assign o_screen_y = r_sy;

endmodule

// ----- rtl/core/perspective_world_to_screen.sv -----
`timescale 1ns / 1ps

// World-to-screen projection: each accepted point goes through matrix rows
// 0, 1 and 2 (two stages), a restoring divider that resolves one quotient bit
// per stage (FRAC_BITS + 34 stages, both axes side by side), and a two-stage
// pixel mapping, at Q16.16 by default. One point is taken every cycle while
// no valid result is stalled; such a stall on the result side freezes the
// whole pipeline. Points with clip w below 0.01 come out not visible with zero
// coordinates. The user must write matrix and screen size through the register
// port only while no transaction is in flight; the block does not enforce it.
module perspective_world_to_screen
    import pws_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_fix        i_pos_x,
    input  t_fix        i_pos_y,
    input  t_fix        i_pos_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_visible,
    output t_fix        o_screen_x,
    output t_fix        o_screen_y
);

    logic [63:0] r_coef [COEF_REGS];
    logic [31:0] r_dims;
    logic [2:0]  reg_idx;
    logic        cfg_wr;
    logic        en;
    t_mat        mat;
    logic        clip_vld;
    t_clip       clip;
    logic        ndc_vld;
    t_ndc        ndc;

    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < COEF_REGS; i++) begin
                r_coef[i] <= '0;
            end
            r_dims <= DIMS_RESET;
        end else if (cfg_wr) begin
            if (reg_idx == 3'(DIMS_IDX)) begin
                r_dims <= pwdata[31:0];
            end else if (reg_idx < 3'(COEF_REGS)) begin
                r_coef[reg_idx] <= pwdata;
            end
        end
    end

    // register read
    always_comb begin
        if (reg_idx == 3'(DIMS_IDX)) begin
            prdata = {32'd0, r_dims};
        end else if (reg_idx < 3'(COEF_REGS)) begin
            prdata = r_coef[reg_idx];
        end else begin
            prdata = '0;
        end
    end

    // unpack matrix rows
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            mat[r][0] = r_coef[2*r][31:0];
            mat[r][1] = r_coef[2*r][63:32];
            mat[r][2] = r_coef[2*r+1][31:0];
            mat[r][3] = r_coef[2*r+1][63:32];
        end
    end

    // pipeline advances unless a held result is stalled
    assign en      = ~(o_valid & i_stall);
    assign o_stall = ~en;

    pws_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_pos_z (i_pos_z),
        .i_mat   (mat),
        .o_valid (clip_vld),
        .o_clip  (clip)
    );

    pws_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (clip_vld),
        .i_clip  (clip),
        .o_valid (ndc_vld),
        .o_ndc   (ndc)
    );

    pws_map #(.FRAC_BITS(FRAC_BITS)) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (ndc_vld),
        .i_ndc      (ndc),
        .i_width    (r_dims[15:0]),
        .i_height   (r_dims[31:16]),
        .o_valid    (o_valid),
        .o_visible  (o_visible),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y)
    );

    // hidden points carry zero coordinates
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_visible) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("hidden point with nonzero coordinates");

    // input side stalls only behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

endmodule
